// ===== hw/rtl/acsp_pkg.sv =====
package acsp_pkg;

    localparam int COLUMNS     = 1024;
    localparam int ROWS        = 4096;
    localparam int SEQ_LEN     = 7;

    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = $clog2(SEQ_LEN + 1);
    localparam int SEQ_IDX_W   = $clog2(SEQ_LEN);
    localparam int IDX_W       = $clog2(SEQ_LEN + 3);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h1B;
    localparam logic [BYTE_W-1:0] LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] FINAL_LO  = 8'h40;
    localparam logic [BYTE_W-1:0] FINAL_HI  = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_1    = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_2    = 8'h32;
    localparam logic [BYTE_W-1:0] CHAR_3    = 8'h33;
    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_F    = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_G    = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_H    = 8'h48;
    localparam logic [BYTE_W-1:0] CHAR_J    = 8'h4A;
    localparam logic [BYTE_W-1:0] CHAR_K    = 8'h4B;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_CLEAR_ROW,
        CMD_CLEAR_SCREEN,
        CMD_ROW_APPENDED
    } acsp_cmd_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_UP,
        OP_CLEAR_SCREEN,
        OP_CLEAR_ROW,
        OP_UP_COL_HOME,
        OP_COL_HOME,
        OP_HOME
    } acsp_op_code_t;

    typedef enum logic [1:0] {
        FS_GROUND,
        FS_ESC,
        FS_CSI,
        FS_REPLAY
    } acsp_front_state_t;

    typedef struct packed {
        acsp_op_code_t     code;
        logic [BYTE_W-1:0] data;
        logic              last;
    } acsp_op_t;

endpackage

// ===== hw/rtl/ansi_csi_screen_command_parser_core.sv =====
// A printable byte's screen command passes the queue, hold register and output register.
// Throughput: one item per cycle for plain bytes while m_tready is high, set by the back end.
// An unknown sequence of n buffered bytes is replayed as n + 2 put operations, holding
// s_tready low until the last of them is queued.
// Reset: rst_n clears the parse phase, cursor, last row, queue and the valid flags at once.
module ansi_csi_screen_command_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // byte_in
    input  logic         s_tuser,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // row [11:0], column [21:12], character [29:22], zero fill
    output logic [2:0]   m_tuser,   // command [1:0], row_overflow [2]
    output logic         m_tlast
);

    logic                 q_ready;
    logic                 q_push;
    acsp_pkg::acsp_op_t   q_in_op;
    logic                 q_valid;
    acsp_pkg::acsp_op_t   q_head_op;
    logic                 q_pop;

    acsp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (q_in_op)
    );

    acsp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in_op),
        .ready   (q_ready),
        .valid   (q_valid),
        .head_op (q_head_op),
        .pop     (q_pop)
    );

    acsp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_op     (q_head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/acsp_front.sv =====
module acsp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [acsp_pkg::BYTE_W-1:0]         s_tdata,
    input  logic                                s_tuser,
    input  logic                                q_ready,
    output logic                                q_push,
    output acsp_pkg::acsp_op_t                  q_op
);

    acsp_pkg::acsp_front_state_t          state_reg;
    acsp_pkg::acsp_front_state_t          state_next;
    logic [acsp_pkg::CNT_W-1:0]           cnt_reg;
    logic [acsp_pkg::CNT_W-1:0]           cnt_next;
    logic [acsp_pkg::IDX_W-1:0]           idx_reg;
    logic [acsp_pkg::IDX_W-1:0]           idx_next;
    logic [acsp_pkg::IDX_W-1:0]           len_reg;
    logic [acsp_pkg::IDX_W-1:0]           len_next;
    logic [acsp_pkg::BYTE_W-1:0]          sec_reg;
    logic [acsp_pkg::BYTE_W-1:0]          sec_next;
    logic [acsp_pkg::BYTE_W-1:0]          seq_reg [acsp_pkg::SEQ_LEN];

    logic                                 accept;
    logic                                 eos;
    logic                                 seq_we;
    logic [acsp_pkg::CNT_W-1:0]           run_cnt;
    logic [acsp_pkg::BYTE_W-1:0]          run_b0;
    logic [acsp_pkg::BYTE_W-1:0]          run_b1;
    logic                                 known;
    acsp_pkg::acsp_op_code_t              known_code;
    logic [acsp_pkg::SEQ_IDX_W-1:0]       rd_idx;
    logic [acsp_pkg::BYTE_W-1:0]          rep_byte;
    logic                                 rep_end;
    logic                                 run_now;

    assign s_tready = (state_reg != acsp_pkg::FS_REPLAY) && q_ready;
    assign accept   = s_tvalid && s_tready;
    assign eos      = s_tuser;

    always_comb
    begin
        run_cnt = eos ? cnt_reg : acsp_pkg::CNT_W'(cnt_reg + 1'b1);
        run_b0  = (!eos && cnt_reg == '0) ? s_tdata : seq_reg[0];
        run_b1  = (!eos && cnt_reg == acsp_pkg::CNT_W'(1)) ? s_tdata : seq_reg[1];

        known      = 1'b0;
        known_code = acsp_pkg::OP_PUT;
        if (run_cnt == acsp_pkg::CNT_W'(2))
        begin
            if (run_b0 == acsp_pkg::CHAR_1 && run_b1 == acsp_pkg::CHAR_A)
            begin
                known      = 1'b1;
                known_code = acsp_pkg::OP_UP;
            end
            else if ((run_b0 == acsp_pkg::CHAR_2 || run_b0 == acsp_pkg::CHAR_3) &&
                     run_b1 == acsp_pkg::CHAR_J)
            begin
                known      = 1'b1;
                known_code = acsp_pkg::OP_CLEAR_SCREEN;
            end
            else if (run_b0 == acsp_pkg::CHAR_2 && run_b1 == acsp_pkg::CHAR_K)
            begin
                known      = 1'b1;
                known_code = acsp_pkg::OP_CLEAR_ROW;
            end
        end
        else if (run_cnt == acsp_pkg::CNT_W'(1))
        begin
            if (run_b0 == acsp_pkg::CHAR_F)
            begin
                known      = 1'b1;
                known_code = acsp_pkg::OP_UP_COL_HOME;
            end
            else if (run_b0 == acsp_pkg::CHAR_G)
            begin
                known      = 1'b1;
                known_code = acsp_pkg::OP_COL_HOME;
            end
            else if (run_b0 == acsp_pkg::CHAR_H)
            begin
                known      = 1'b1;
                known_code = acsp_pkg::OP_HOME;
            end
        end

        rd_idx = (idx_reg >= acsp_pkg::IDX_W'(2)) ?
                 acsp_pkg::SEQ_IDX_W'(idx_reg - acsp_pkg::IDX_W'(2)) : '0;
        if (idx_reg == '0)
        begin
            rep_byte = acsp_pkg::ESC_BYTE;
        end
        else if (idx_reg == acsp_pkg::IDX_W'(1))
        begin
            rep_byte = sec_reg;
        end
        else
        begin
            rep_byte = seq_reg[rd_idx];
        end
        rep_end = (idx_reg == acsp_pkg::IDX_W'(len_reg - acsp_pkg::IDX_W'(1)));

        run_now = eos || (s_tdata inside {[acsp_pkg::FINAL_LO:acsp_pkg::FINAL_HI]}) ||
                  (run_cnt >= acsp_pkg::CNT_W'(acsp_pkg::SEQ_LEN));
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        sec_next     = sec_reg;
        seq_we       = 1'b0;
        q_push       = 1'b0;
        q_op.code    = acsp_pkg::OP_PUT;
        q_op.data    = s_tdata;
        q_op.last    = 1'b1;

        case (state_reg)
            acsp_pkg::FS_GROUND:
            begin
                if (accept && !eos)
                begin
                    if (s_tdata == acsp_pkg::ESC_BYTE)
                    begin
                        state_next = acsp_pkg::FS_ESC;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
                if (accept)
                begin
                    cnt_next = '0;
                end
            end
            acsp_pkg::FS_ESC:
            begin
                if (accept)
                begin
                    state_next = acsp_pkg::FS_GROUND;
                    cnt_next   = '0;
                    if (!eos)
                    begin
                        if (s_tdata == acsp_pkg::LBRACKET)
                        begin
                            state_next = acsp_pkg::FS_CSI;
                        end
                        else
                        begin
                            state_next = acsp_pkg::FS_REPLAY;
                            sec_next   = s_tdata;
                            len_next   = acsp_pkg::IDX_W'(2);
                            idx_next   = '0;
                        end
                    end
                end
            end
            acsp_pkg::FS_CSI:
            begin
                if (accept)
                begin
                    if (!eos)
                    begin
                        seq_we   = 1'b1;
                        cnt_next = run_cnt;
                    end
                    if (run_now)
                    begin
                        cnt_next = '0;
                        if (known)
                        begin
                            state_next = acsp_pkg::FS_GROUND;
                            q_push     = 1'b1;
                            q_op.code  = known_code;
                        end
                        else
                        begin
                            state_next = acsp_pkg::FS_REPLAY;
                            sec_next   = acsp_pkg::LBRACKET;
                            len_next   = acsp_pkg::IDX_W'(acsp_pkg::IDX_W'(run_cnt) +
                                                          acsp_pkg::IDX_W'(2));
                            idx_next   = '0;
                        end
                    end
                end
            end
            acsp_pkg::FS_REPLAY:
            begin
                if (q_ready)
                begin
                    q_push    = 1'b1;
                    q_op.data = rep_byte;
                    q_op.last = rep_end;
                    idx_next  = acsp_pkg::IDX_W'(idx_reg + 1'b1);
                    if (rep_end)
                    begin
                        state_next = acsp_pkg::FS_GROUND;
                    end
                end
            end
            default:
            begin
                state_next = acsp_pkg::FS_GROUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acsp_pkg::FS_GROUND;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg <= sec_next;
        if (seq_we && cnt_reg < acsp_pkg::CNT_W'(acsp_pkg::SEQ_LEN))
        begin
            seq_reg[cnt_reg[acsp_pkg::SEQ_IDX_W-1:0]] <= s_tdata;
        end
    end

endmodule

// ===== hw/rtl/acsp_queue.sv =====
module acsp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  acsp_pkg::acsp_op_t   push_op,
    output logic                 ready,
    output logic                 valid,
    output acsp_pkg::acsp_op_t   head_op,
    input  logic                 pop
);

    acsp_pkg::acsp_op_t                mem [acsp_pkg::QUEUE_DEPTH];
    logic [acsp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [acsp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [acsp_pkg::QPTR_W:0]         count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign ready   = (count_reg != (acsp_pkg::QPTR_W + 1)'(acsp_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head_op = mem[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= acsp_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= acsp_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= (acsp_pkg::QPTR_W + 1)'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= (acsp_pkg::QPTR_W + 1)'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hw/rtl/acsp_back.sv =====
module acsp_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  acsp_pkg::acsp_op_t   q_op,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    typedef struct packed {
        acsp_pkg::acsp_cmd_t               cmd;
        logic [acsp_pkg::ROW_W-1:0]        row;
        logic [acsp_pkg::COL_W-1:0]        col;
        logic [acsp_pkg::BYTE_W-1:0]       ch;
        logic                              ovf;
    } res_t;

    logic [acsp_pkg::ROW_W-1:0]   row_reg;
    logic [acsp_pkg::ROW_W-1:0]   row_next;
    logic [acsp_pkg::COL_W-1:0]   col_reg;
    logic [acsp_pkg::COL_W-1:0]   col_next;
    logic [acsp_pkg::ROW_W-1:0]   last_row_reg;
    logic [acsp_pkg::ROW_W-1:0]   last_row_next;

    res_t                         res;
    logic                         res_valid;
    res_t                         hold_reg;
    logic                         hold_valid_reg;
    logic                         hold_valid_next;
    logic                         hold_final_reg;
    logic                         hold_final_next;
    res_t                         out_reg;
    logic                         out_valid_reg;
    logic                         out_last_reg;

    logic                         out_free;
    logic                         exec;
    logic                         move;

    assign out_free = !out_valid_reg || m_tready;
    assign exec     = q_valid && (!hold_valid_reg || out_free);
    assign q_pop    = exec;
    assign move     = hold_valid_reg && out_free && (hold_final_reg || (exec && res_valid));

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        last_row_next = last_row_reg;
        res_valid     = 1'b0;
        res.cmd       = acsp_pkg::CMD_WRITE;
        res.row       = row_reg;
        res.col       = '0;
        res.ch        = '0;
        res.ovf       = 1'b0;

        case (q_op.code)
            acsp_pkg::OP_PUT:
            begin
                if (q_op.data == acsp_pkg::NEWLINE)
                begin
                    col_next = '0;
                    if (row_reg >= acsp_pkg::ROW_W'(acsp_pkg::ROWS - 1))
                    begin
                        res_valid = 1'b1;
                        res.cmd   = acsp_pkg::CMD_ROW_APPENDED;
                        res.ovf   = 1'b1;
                    end
                    else
                    begin
                        row_next = acsp_pkg::ROW_W'(row_reg + 1'b1);
                        if (row_reg == last_row_reg)
                        begin
                            last_row_next = acsp_pkg::ROW_W'(row_reg + 1'b1);
                            res_valid     = 1'b1;
                            res.cmd       = acsp_pkg::CMD_ROW_APPENDED;
                            res.row       = acsp_pkg::ROW_W'(row_reg + 1'b1);
                        end
                    end
                end
                else if (col_reg < acsp_pkg::COL_W'(acsp_pkg::COLUMNS - 1))
                begin
                    res_valid = 1'b1;
                    res.col   = col_reg;
                    res.ch    = q_op.data;
                    col_next  = acsp_pkg::COL_W'(col_reg + 1'b1);
                end
            end
            acsp_pkg::OP_UP:
            begin
                if (row_reg != '0)
                begin
                    row_next = acsp_pkg::ROW_W'(row_reg - 1'b1);
                end
            end
            acsp_pkg::OP_CLEAR_SCREEN:
            begin
                row_next      = '0;
                col_next      = '0;
                last_row_next = '0;
                res_valid     = 1'b1;
                res.cmd       = acsp_pkg::CMD_CLEAR_SCREEN;
                res.row       = '0;
            end
            acsp_pkg::OP_CLEAR_ROW:
            begin
                res_valid = 1'b1;
                res.cmd   = acsp_pkg::CMD_CLEAR_ROW;
            end
            acsp_pkg::OP_UP_COL_HOME:
            begin
                col_next = '0;
                if (row_reg != '0)
                begin
                    row_next = acsp_pkg::ROW_W'(row_reg - 1'b1);
                end
            end
            acsp_pkg::OP_COL_HOME:
            begin
                col_next = '0;
            end
            acsp_pkg::OP_HOME:
            begin
                row_next = '0;
                col_next = '0;
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // The held result is released once it is known whether it is the last of its item.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        if (move)
        begin
            hold_valid_next = 1'b0;
        end
        if (exec)
        begin
            if (res_valid)
            begin
                hold_valid_next = 1'b1;
                hold_final_next = q_op.last;
            end
            else if (q_op.last)
            begin
                hold_final_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            last_row_reg   <= '0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                row_reg      <= row_next;
                col_reg      <= col_next;
                last_row_reg <= last_row_next;
            end
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && res_valid)
        begin
            hold_reg <= res;
        end
        if (move)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= hold_final_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.ch, out_reg.col, out_reg.row};
    assign m_tuser  = {out_reg.ovf, out_reg.cmd};
    assign m_tlast  = out_last_reg;

endmodule
